// ===== rtl/core/mfbp_pkg.sv =====
// Shared constants and types for the MSB-first bit packer.
// No dependencies; every other file depends on this package.
package mfbp_pkg;

    localparam int MAX_FIELD_BITS = 64;
    localparam int BYTE_BITS      = 8;
    localparam int VAL_W          = 64;
    localparam int CNT_W          = 7;
    localparam int PEND_W         = BYTE_BITS - 1;
    localparam int PCNT_W         = 3;
    localparam int COMB_W         = MAX_FIELD_BITS + PEND_W;
    localparam int MAX_BYTES      = (MAX_FIELD_BITS + PEND_W) / BYTE_BITS;
    localparam int DATA_W         = MAX_BYTES * BYTE_BITS;
    localparam int NB_W           = $clog2(MAX_BYTES + 1);
    localparam int IDX_W          = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = 1;
    localparam int QCNT_W         = 2;

    typedef enum logic {
        CMD_PUSH  = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    // One queued job: the finished bytes, right-aligned, earliest byte highest.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [NB_W-1:0]   nbytes;
    } t_entry;

endpackage

// ===== rtl/core/mfbp_if.sv =====
// Valid/ready channel interfaces for the bit packer input and output.
// Depends on mfbp_pkg.
interface mfbp_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [mfbp_pkg::VAL_W-1:0] field_value;
    logic [mfbp_pkg::CNT_W-1:0] bit_count;

    modport source (output valid, output cmd, output field_value, output bit_count,
                    input ready);
    modport sink   (input valid, input cmd, input field_value, input bit_count,
                    output ready);
endinterface

interface mfbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== rtl/core/mfbp_front.sv =====
// Front end: accepts transactions, merges them with the pending bits and
// hands each run of completed bytes to the queue. Depends on mfbp_pkg, mfbp_if.
module mfbp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mfbp_in_if.sink              i_in_ch,
    input  logic                 i_q_full,
    output logic                 o_q_wr,
    output mfbp_pkg::t_entry     o_q_entry
);
    import mfbp_pkg::*;

    logic [PEND_W-1:0] r_pend_bits, n_pend_bits;
    logic [PCNT_W-1:0] r_pend_cnt,  n_pend_cnt;

    logic              accept;
    logic [CNT_W-1:0]  sat_cnt;
    logic [VAL_W-1:0]  val_masked;
    logic [COMB_W-1:0] comb;
    logic [CNT_W-1:0]  total;
    logic [PCNT_W-1:0] rem;
    logic [BYTE_BITS-1:0] flush_byte;

    assign i_in_ch.ready = !i_q_full;
    assign accept = i_in_ch.valid && !i_q_full;

    always_comb begin
        sat_cnt = (i_in_ch.bit_count > CNT_W'(MAX_FIELD_BITS))
                  ? CNT_W'(MAX_FIELD_BITS) : i_in_ch.bit_count;
        // a shift of 64 or more clears the word, so a full count keeps every bit
        val_masked = i_in_ch.field_value & ~({VAL_W{1'b1}} << sat_cnt);
        comb  = ({{(COMB_W-PEND_W){1'b0}}, r_pend_bits} << sat_cnt)
                | COMB_W'(val_masked);
        total = CNT_W'(r_pend_cnt) + sat_cnt;
        rem   = total[PCNT_W-1:0];
        flush_byte = BYTE_BITS'({1'b0, r_pend_bits}
                     << (4'(BYTE_BITS) - {1'b0, r_pend_cnt}));

        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        o_q_wr      = 1'b0;
        o_q_entry.data   = DATA_W'(comb >> rem);
        o_q_entry.nbytes = NB_W'(total >> PCNT_W);

        if (i_in_ch.cmd == CMD_FLUSH) begin
            o_q_entry.data   = DATA_W'(flush_byte);
            o_q_entry.nbytes = NB_W'(r_pend_cnt != '0);
            if (accept) begin
                o_q_wr      = (r_pend_cnt != '0);
                n_pend_bits = '0;
                n_pend_cnt  = '0;
            end
        end else if (accept) begin
            o_q_wr      = (o_q_entry.nbytes != '0);
            n_pend_bits = comb[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
            n_pend_cnt  = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else begin
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

endmodule

// ===== rtl/core/mfbp_queue.sv =====
// Two-entry job queue between the front and back ends.
// Depends on mfbp_pkg.
module mfbp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  mfbp_pkg::t_entry i_wr_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_rd_valid,
    output mfbp_pkg::t_entry o_rd_entry
);
    import mfbp_pkg::*;

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_wr, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/mfbp_back.sv =====
// Back end: walks a queued job into the output register, one byte per cycle
// while it is free, and marks each job's final byte. Depends on mfbp_pkg, mfbp_if.
module mfbp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_valid,
    input  mfbp_pkg::t_entry i_rd_entry,
    output logic             o_pop,
    mfbp_out_if.source       o_out_ch
);
    import mfbp_pkg::*;

    logic [DATA_W-1:0]    r_data;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_busy;
    logic                 r_out_valid;
    logic [BYTE_BITS-1:0] r_out_byte;
    logic                 r_out_last;

    logic out_free;
    logic advance;

    assign out_free = !r_out_valid || o_out_ch.ready;
    assign advance  = r_busy && out_free;
    assign o_pop    = i_rd_valid && (!r_busy || (advance && r_idx == '0));

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.out_byte    = r_out_byte;
    assign o_out_ch.last_of_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= r_data[BYTE_BITS*r_idx +: BYTE_BITS];
            r_out_last <= (r_idx == '0);
        end
        if (o_pop) begin
            r_data <= i_rd_entry.data;
            r_idx  <= IDX_W'(i_rd_entry.nbytes - 1'b1);
        end else if (advance) begin
            r_idx  <= r_idx - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (advance && r_idx == '0) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/msb_first_bit_packer_unit.sv =====
// MSB-first bit packer: appends 0..64-bit fields to a byte stream, earliest
// bit in bit 7, and emits a zero-padded partial byte on flush; the last byte
// caused by each input transaction carries last_of_run. The front end takes
// one transaction per cycle while its two-entry queue has room; a transaction
// that completes N bytes (0..8) then holds the back end while they go out one
// byte per cycle through the registered output while the output is ready, so
// sustained throughput is set by the single-byte output channel.
// Depends on mfbp_pkg, mfbp_if, mfbp_front, mfbp_queue, mfbp_back.
module msb_first_bit_packer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfbp_in_if.sink     i_in_ch,
    mfbp_out_if.source  o_out_ch
);
    import mfbp_pkg::*;

    logic   q_wr;
    logic   q_full;
    logic   q_pop;
    logic   q_rd_valid;
    t_entry q_wr_entry;
    t_entry q_rd_entry;

    mfbp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_ch   (i_in_ch),
        .i_q_full  (q_full),
        .o_q_wr    (q_wr),
        .o_q_entry (q_wr_entry)
    );

    mfbp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (q_wr),
        .i_wr_entry (q_wr_entry),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_rd_valid (q_rd_valid),
        .o_rd_entry (q_rd_entry)
    );

    mfbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_valid (q_rd_valid),
        .i_rd_entry (q_rd_entry),
        .o_pop      (q_pop),
        .o_out_ch   (o_out_ch)
    );

endmodule

// ===== verif/msb_first_bit_packer_unit_tb.sv =====
// Self-checking testbench for msb_first_bit_packer_unit: a directed table followed by random
// push/flush transactions, each output byte checked against its table row or a local bit-packing
// model. Depends on mfbp_pkg, mfbp_if and the packer RTL.
module msb_first_bit_packer_unit_tb;
    import mfbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 385;
    localparam int QUIET_TAIL     = 60;
    localparam int DRAIN_CYCLES   = 20;

    // Up to eight bytes caused by one transaction, earliest byte in bits 63:56.
    typedef struct packed {
        logic [3:0]  n;
        logic [63:0] bytes;
    } t_burst;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_byte;

    typedef struct {
        t_cmd        cmd;
        logic [63:0] value;
        logic [6:0]  count;
        bit          typed;
        t_burst      want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    mfbp_in_if  in_ch ();
    mfbp_out_if out_ch ();

    msb_first_bit_packer_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    // Packer model state.
    logic [6:0] held_bits;
    logic [2:0] held_cnt;

    t_out_byte owed_bytes[$];
    t_row      dir_rows[$];
    int        mismatch_cnt;
    int        quiet_cycles;
    bit        idling_en;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Appends the kept bits MSB first, or pads the held bits on flush; returns the bytes this transaction completes.
    function automatic t_burst pack_bits(t_cmd c, logic [63:0] v, logic [6:0] cnt);
        t_burst      r;
        logic [7:0]  acc;
        logic [15:0] shifted;
        int          have;
        int          nbits;
        r = '0;
        if (c == CMD_FLUSH) begin
            if (held_cnt != 3'd0) begin
                shifted = 16'(held_bits) << (BYTE_BITS - int'(held_cnt));
                r.bytes[63:56] = shifted[7:0];
                r.n = 4'd1;
            end
            held_bits = '0;
            held_cnt  = '0;
        end else begin
            nbits = (int'(cnt) > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(cnt);
            acc  = {1'b0, held_bits};
            have = int'(held_cnt);
            for (int k = nbits - 1; k >= 0; k--) begin
                acc  = {acc[6:0], v[k]};
                have = have + 1;
                if (have == BYTE_BITS) begin
                    r.bytes[63 - 8 * int'(r.n) -: 8] = acc;
                    r.n  = r.n + 4'd1;
                    acc  = '0;
                    have = 0;
                end
            end
            held_bits = acc[6:0];
            held_cnt  = 3'(have);
        end
        return r;
    endfunction

    task automatic add_row(t_cmd c, logic [63:0] v, logic [6:0] cnt, bit typed,
                           int n, logic [63:0] bytes);
        t_row row;
        row.cmd     = c;
        row.value   = v;
        row.count   = cnt;
        row.typed   = typed;
        row.want.n  = 4'(n);
        row.want.bytes = bytes;
        dir_rows.push_back(row);
    endtask

    function automatic void note_mismatch(string what, logic [7:0] want, logic [7:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch %s: expected %02h actual %02h", what, want, got);
    endfunction

    // Drives one transaction, waits for acceptance, then books its expected bytes.
    task automatic send_txn(t_cmd c, logic [63:0] v, logic [6:0] cnt, bit typed,
                            t_burst want);
        t_burst    got;
        t_out_byte ob;
        if (idling_en && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= c;
        in_ch.field_value <= v;
        in_ch.bit_count   <= cnt;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        got = pack_bits(c, v, cnt);
        if (typed)
            got = want;
        for (int k = 0; k < int'(got.n); k++) begin
            ob.out_byte    = got.bytes[63 - 8 * k -: 8];
            ob.last_of_run = (k == int'(got.n) - 1);
            owed_bytes.push_back(ob);
        end
    endtask

    // Drops valid and waits for a clock edge before waiting for all owed bytes, so valid is driven once per time step.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (owed_bytes.size() != 0) @(posedge i_clk);
    endtask

    // Stimulus and end of run.
    initial begin
        t_burst     none;
        t_cmd       c;
        logic [63:0] v;
        logic [6:0] cnt;
        int         pick;
        none = '0;
        mismatch_cnt = 0;
        idling_en    = 1'b1;
        held_bits    = '0;
        held_cnt     = '0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.cmd         <= CMD_PUSH;
        in_ch.field_value <= '0;
        in_ch.bit_count   <= '0;

        // After reset: empty flush and empty push give nothing; full 64-bit pushes give eight bytes.
        add_row(CMD_FLUSH, 64'h0,                  7'd0,   1, 0, 64'h0);
        add_row(CMD_PUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd0,   1, 0, 64'h0);
        add_row(CMD_PUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd64,  1, 8, 64'hFFFF_FFFF_FFFF_FFFF);
        add_row(CMD_PUSH,  64'h0123_4567_89AB_CDEF, 7'd64,  1, 8, 64'h0123_4567_89AB_CDEF);
        // Oversized counts saturate to 64 bits.
        add_row(CMD_PUSH,  64'h8000_0000_0000_0001, 7'd127, 1, 8, 64'h8000_0000_0000_0001);
        add_row(CMD_PUSH,  64'h0,                  7'd65,  1, 8, 64'h0);
        // Partial byte: only low three bits kept, flush pads right.
        add_row(CMD_PUSH,  64'hFFFF_FFFF_FFFF_FFF5, 7'd3,   1, 0, 64'h0);
        add_row(CMD_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1, 1, 64'hA000_0000_0000_0000);
        add_row(CMD_FLUSH, 64'h0,                  7'd0,   1, 0, 64'h0);
        add_row(CMD_PUSH,  64'h1,                  7'd1,   1, 0, 64'h0);
        add_row(CMD_PUSH,  64'h7F,                 7'd7,   1, 1, 64'hFF00_0000_0000_0000);
        add_row(CMD_PUSH,  64'h55,                 7'd7,   1, 0, 64'h0);
        add_row(CMD_PUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd64,  0, 0, 64'h0);
        add_row(CMD_FLUSH, 64'h0,                  7'd0,   1, 1, 64'hFE00_0000_0000_0000);
        add_row(CMD_PUSH,  64'hA,                  7'd4,   1, 0, 64'h0);
        add_row(CMD_PUSH,  64'h5,                  7'd4,   1, 1, 64'hA500_0000_0000_0000);
        add_row(CMD_PUSH,  64'hABC,                7'd12,  1, 1, 64'hAB00_0000_0000_0000);
        add_row(CMD_PUSH,  64'hDEAD_BEEF_CAFE_F00D, 7'd63,  0, 0, 64'h0);
        add_row(CMD_PUSH,  64'hFFFF_FFFF_FFFF_FF00, 7'd8,   0, 0, 64'h0);
        add_row(CMD_PUSH,  64'h0,                  7'd64,  0, 0, 64'h0);
        add_row(CMD_PUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 0, 0, 64'h0);
        add_row(CMD_FLUSH, 64'h0,                  7'd0,   0, 0, 64'h0);
        add_row(CMD_PUSH,  64'h5555_5555_5555_5555, 7'd100, 0, 0, 64'h0);
        add_row(CMD_PUSH,  64'h3,                  7'd2,   0, 0, 64'h0);
        add_row(CMD_FLUSH, 64'h0,                  7'd0,   0, 0, 64'h0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_txn(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].count,
                     dir_rows[i].typed, dir_rows[i].want);
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            if (i == RANDOM_ITEMS - QUIET_TAIL)
                idling_en = 1'b0;
            pick = $urandom_range(0, 99);
            v    = {$urandom, $urandom};
            c    = CMD_PUSH;
            if (pick < 15) begin
                c   = CMD_FLUSH;
                cnt = 7'($urandom_range(0, 127));
            end else if (pick < 55) begin
                cnt = 7'($urandom_range(0, 8));
            end else if (pick < 80) begin
                cnt = 7'($urandom_range(9, 32));
            end else if (pick < 95) begin
                cnt = 7'($urandom_range(33, 64));
            end else begin
                cnt = 7'($urandom_range(65, 127));
            end
            send_txn(c, v, cnt, 1'b0, none);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Output side: ready drops in short random bursts while idling is on.
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            if (idling_en && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
        end
    end

    // Byte checker.
    always @(posedge i_clk) begin
        t_out_byte want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (owed_bytes.size() == 0) begin
                note_mismatch("unexpected byte", 8'h00, out_ch.out_byte);
            end else begin
                want = owed_bytes.pop_front();
                if (out_ch.out_byte !== want.out_byte)
                    note_mismatch("out_byte", want.out_byte, out_ch.out_byte);
                if (out_ch.last_of_run !== want.last_of_run)
                    note_mismatch("last_of_run", 8'(want.last_of_run),
                                  8'(out_ch.last_of_run));
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial quiet_cycles = 0;

endmodule
